// ===== design/psq_pkg.sv =====
// Shared codes for the positional sequence store: operation and status encodings.
// No dependencies.
package psq_pkg;

  typedef logic [2:0] op_t;
  typedef logic [1:0] status_t;

  localparam op_t OP_INS_FRONT = 3'd0;
  localparam op_t OP_INS_BACK  = 3'd1;
  localparam op_t OP_DEL_FRONT = 3'd2;
  localparam op_t OP_DEL_BACK  = 3'd3;
  localparam op_t OP_INS_AT    = 3'd4;
  localparam op_t OP_DEL_AT    = 3'd5;
  localparam op_t OP_READ_ALL  = 3'd6;

  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_BADPOS = 2'd1;
  localparam status_t ST_FULL   = 2'd2;
  localparam status_t ST_EMPTY  = 2'd3;

endpackage

// ===== design/psq_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module psq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/positional_sequence_store_core.sv =====
// Positional sequence store: an ordered list of signed words with front, back and
// positional insert/delete plus full read-out. The elements sit in one RAM (registered
// read, one write port), shifted one entry per cycle when a hole is opened or closed.
// Timing: start is taken whenever busy is low. Front/back inserts at the tail, tail
// deletes, refused operations and unused codes finish at once: the result strobes on
// the next cycle and a new command may be issued in that same cycle. An insert or a delete
// that must move k entries keeps busy high through S_SHIFT and then S_FIN, an insert also
// through S_PUT after them; k is at most CAPACITY-1.
// Read-out of n elements streams one element per cycle with out_last on the final one.
// The receiver cannot stall: every result is shown for exactly one
// cycle under out_valid and must be taken then. Depends on psq_pkg and psq_ram.
module positional_sequence_store_core #(
  parameter int CAPACITY   = 32,
  parameter int DATA_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  psq_pkg::op_t           in_op,
  input  logic signed [31:0]     in_value,
  input  logic [5:0]             in_position,
  output logic                   out_valid,
  output psq_pkg::status_t       out_status,
  output logic [5:0]             out_element_count,
  output logic signed [31:0]     out_element,
  output logic                   out_last
);
  import psq_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {S_IDLE, S_SHIFT, S_FIN, S_PUT, S_READ} state_t;

  state_t                state_r;
  logic [CW-1:0]         cnt_r;
  logic [AW-1:0]         ptr_r;
  logic [AW-1:0]         idx_r;
  logic [DATA_WIDTH-1:0] val_r;
  logic                  dir_ins_r;
  logic                  wv_r;
  logic [AW-1:0]         wa_r;
  logic                  res_v_r;
  status_t               status_r;
  logic                  emit_r;
  logic                  elast_r;

  // decode
  logic [6:0]    c7, p7, ins_slot, del_slot;
  logic          is_ins, is_del, ins_bad, del_bad, full, empty, ins_append, del_tail;
  logic [AW-1:0] last_idx;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic [DATA_WIDTH-1:0] ram_rdata;

  always_comb begin
    c7       = 7'(cnt_r);
    p7       = 7'(in_position);
    is_ins   = (in_op inside {OP_INS_FRONT, OP_INS_BACK, OP_INS_AT});
    is_del   = (in_op inside {OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_AT});
    full     = (cnt_r == CW'(CAPACITY));
    empty    = (cnt_r == '0);
    ins_bad  = (in_op == OP_INS_AT) && ((p7 == 7'd0) || (p7 > c7 + 7'd1));
    del_bad  = (in_op == OP_DEL_AT) && ((p7 == 7'd0) || (p7 > c7));
    case (in_op)
      OP_INS_FRONT: ins_slot = 7'd0;
      OP_INS_BACK:  ins_slot = c7;
      default:      ins_slot = p7 - 7'd1;
    endcase
    case (in_op)
      OP_DEL_FRONT: del_slot = 7'd0;
      OP_DEL_BACK:  del_slot = c7 - 7'd1;
      default:      del_slot = p7 - 7'd1;
    endcase
    ins_append = (ins_slot == c7);
    del_tail   = (del_slot == c7 - 7'd1);
    last_idx   = AW'(cnt_r - CW'(1));
  end

  assign busy = (state_r != S_IDLE);

  // write port: shift write-back, then held value, then direct tail append
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AW'(ins_slot);
    ram_wdata = DATA_WIDTH'(in_value);
    if (wv_r) begin
      ram_we    = 1'b1;
      ram_waddr = wa_r;
      ram_wdata = ram_rdata;
    end else if (state_r == S_PUT) begin
      ram_we    = 1'b1;
      ram_waddr = idx_r;
      ram_wdata = val_r;
    end else if (state_r == S_IDLE && start && is_ins && !ins_bad && !full && ins_append) begin
      ram_we    = 1'b1;
    end
  end

  psq_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ptr_r),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      ptr_r   <= '0;
      wv_r    <= 1'b0;
      res_v_r <= 1'b0;
      emit_r  <= 1'b0;
    end else begin
      res_v_r <= 1'b0;
      emit_r  <= 1'b0;
      wv_r    <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            if (is_ins) begin
              if (ins_bad) begin
                res_v_r  <= 1'b1;
                status_r <= ST_BADPOS;
              end else if (full) begin
                res_v_r  <= 1'b1;
                status_r <= ST_FULL;
              end else if (ins_append) begin
                cnt_r    <= cnt_r + CW'(1);
                res_v_r  <= 1'b1;
                status_r <= ST_OK;
              end else begin
                val_r     <= DATA_WIDTH'(in_value);
                idx_r     <= AW'(ins_slot);
                ptr_r     <= last_idx;
                dir_ins_r <= 1'b1;
                state_r   <= S_SHIFT;
              end
            end else if (is_del) begin
              if (empty) begin
                res_v_r  <= 1'b1;
                status_r <= ST_EMPTY;
              end else if (del_bad) begin
                res_v_r  <= 1'b1;
                status_r <= ST_BADPOS;
              end else if (del_tail) begin
                cnt_r    <= cnt_r - CW'(1);
                res_v_r  <= 1'b1;
                status_r <= ST_OK;
              end else begin
                ptr_r     <= AW'(del_slot + 7'd1);
                dir_ins_r <= 1'b0;
                state_r   <= S_SHIFT;
              end
            end else if (in_op == OP_READ_ALL) begin
              if (empty) begin
                res_v_r  <= 1'b1;
                status_r <= ST_EMPTY;
              end else begin
                ptr_r   <= '0;
                state_r <= S_READ;
              end
            end else begin
              res_v_r  <= 1'b1;
              status_r <= ST_OK;
            end
          end
        end
        S_SHIFT: begin
          // entry read now is written back one slot over on the next cycle
          wv_r <= 1'b1;
          wa_r <= dir_ins_r ? ptr_r + AW'(1) : ptr_r - AW'(1);
          if (dir_ins_r ? (ptr_r == idx_r) : (ptr_r == last_idx)) begin
            state_r <= S_FIN;
          end else begin
            ptr_r <= dir_ins_r ? ptr_r - AW'(1) : ptr_r + AW'(1);
          end
        end
        S_FIN: begin
          if (dir_ins_r) begin
            state_r <= S_PUT;
          end else begin
            cnt_r    <= cnt_r - CW'(1);
            res_v_r  <= 1'b1;
            status_r <= ST_OK;
            state_r  <= S_IDLE;
          end
        end
        S_PUT: begin
          cnt_r    <= cnt_r + CW'(1);
          res_v_r  <= 1'b1;
          status_r <= ST_OK;
          state_r  <= S_IDLE;
        end
        S_READ: begin
          emit_r  <= 1'b1;
          elast_r <= (ptr_r == last_idx);
          if (ptr_r == last_idx) begin
            state_r <= S_IDLE;
          end else begin
            ptr_r <= ptr_r + AW'(1);
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid         = res_v_r | emit_r;
  assign out_status        = emit_r ? ST_OK : status_r;
  assign out_element_count = 6'(cnt_r);
  assign out_element       = emit_r ? 32'($signed(ram_rdata)) : '0;
  assign out_last          = emit_r ? elast_r : 1'b1;

endmodule

// ===== tb/tb_positional_sequence_store_core.sv =====
// Self-checking testbench for positional_sequence_store_core: directed corner cases and
// random list traffic with its own list predictor. Every strobed result is checked in order.
// Depends on psq_pkg and the core (with its RAM).
module tb_positional_sequence_store_core;
  import psq_pkg::*;

  localparam int  CAPACITY   = 32;
  localparam int  DATA_WIDTH = 32;
  localparam op_t OP_UNUSED  = 3'd7;
  localparam int  DRAIN_CYCLES = 40;

  typedef struct packed {
    status_t            status;
    logic [5:0]         count;
    logic signed [31:0] element;
    logic               last;
  } list_result_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  op_t                in_op;
  logic signed [31:0] in_value;
  logic [5:0]         in_position;
  logic               out_valid;
  status_t            out_status;
  logic [5:0]         out_element_count;
  logic signed [31:0] out_element;
  logic               out_last;

  // predicted list contents and the results still to come
  logic signed [31:0] list_mem [0:CAPACITY-1];
  int unsigned        list_len;
  list_result_t       pending_results [$];

  int unsigned mismatches;
  int unsigned items_sent;
  int unsigned no_gap_left;

  positional_sequence_store_core #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_op             (in_op),
    .in_value          (in_value),
    .in_position       (in_position),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_element_count (out_element_count),
    .out_element       (out_element),
    .out_last          (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // ---------------- list predictor ----------------
  function automatic void push_result(status_t st, logic signed [31:0] elem, logic lst);
    list_result_t r;
    r.status  = st;
    r.count   = list_len[5:0];
    r.element = elem;
    r.last    = lst;
    pending_results.push_back(r);
  endfunction

  function automatic void list_insert(int unsigned slot, logic signed [31:0] val);
    for (int unsigned i = list_len; i > slot; i--) list_mem[i] = list_mem[i-1];
    list_mem[slot] = val;
    list_len++;
  endfunction

  function automatic void list_delete(int unsigned slot);
    for (int unsigned i = slot; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
    list_len--;
  endfunction

  function automatic void predict_list_op(op_t op, logic signed [31:0] val, logic [5:0] pos);
    status_t st;
    st = ST_OK;
    case (op)
      OP_INS_FRONT, OP_INS_BACK: begin
        if (list_len >= CAPACITY) st = ST_FULL;
        else list_insert((op == OP_INS_FRONT) ? 0 : list_len, val);
      end
      OP_DEL_FRONT, OP_DEL_BACK: begin
        if (list_len == 0) st = ST_EMPTY;
        else list_delete((op == OP_DEL_FRONT) ? 0 : list_len - 1);
      end
      OP_INS_AT: begin
        // position is checked before fullness
        if (pos < 1 || pos > list_len + 1) st = ST_BADPOS;
        else if (list_len >= CAPACITY) st = ST_FULL;
        else list_insert(pos - 1, val);
      end
      OP_DEL_AT: begin
        if (list_len == 0) st = ST_EMPTY;
        else if (pos < 1 || pos > list_len) st = ST_BADPOS;
        else list_delete(pos - 1);
      end
      OP_READ_ALL: begin
        if (list_len == 0) st = ST_EMPTY;
        else st = ST_OK;
      end
      default: st = ST_OK;
    endcase
    if (op == OP_READ_ALL && list_len != 0) begin
      for (int unsigned i = 0; i < list_len; i++)
        push_result(ST_OK, list_mem[i], (i + 1 == list_len));
    end else begin
      push_result(st, '0, 1'b1);
    end
  endfunction

  // ---------------- result checking ----------------
  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d count %0d element %0d last %0b",
                   out_status, out_element_count, out_element, out_last);
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status || out_element_count !== want.count ||
            out_element !== want.element || out_last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp status %0d count %0d element %0d last %0b, got %0d %0d %0d %0b",
                     want.status, want.count, want.element, want.last,
                     out_status, out_element_count, out_element, out_last);
        end
      end
    end
  end

  // ---------------- stimulus helpers ----------------
  task automatic send_item(op_t op, logic signed [31:0] val, logic [5:0] pos);
    int unsigned gap;
    if (no_gap_left > 0) begin
      gap = 0;
      no_gap_left--;
    end else begin
      gap = $urandom_range(0, 19);
      if ($urandom_range(0, 19) == 0) no_gap_left = $urandom_range(10, 40);
    end
    @(negedge clk);
    if (gap > 0) begin
      start       <= 1'b0;
      in_op       <= op_t'($urandom_range(0, 7));
      in_value    <= $urandom;
      in_position <= 6'($urandom_range(0, 63));
      repeat (gap) @(negedge clk);
    end
    start       <= 1'b1;
    in_op       <= op;
    in_value    <= val;
    in_position <= pos;
    // transfer happens at the first rising edge with busy low
    do @(posedge clk); while (busy);
    predict_list_op(op, val, pos);
    items_sent++;
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 39))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2:       return 32'sd0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [5:0] pick_position(op_t op);
    if ($urandom_range(0, 99) < 15) return 6'($urandom_range(0, 63));
    if (op == OP_INS_AT) return 6'($urandom_range(1, list_len + 1));
    if (list_len == 0) return 6'($urandom_range(0, 63));
    return 6'($urandom_range(1, list_len));
  endfunction

  // fill_pct: share of list-changing ops that insert
  function automatic op_t pick_op(int unsigned fill_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 2) return OP_UNUSED;
    if (r < 10) return OP_READ_ALL;
    if ($urandom_range(0, 99) < fill_pct) begin
      case ($urandom_range(0, 2))
        0:       return OP_INS_FRONT;
        1:       return OP_INS_BACK;
        default: return OP_INS_AT;
      endcase
    end
    case ($urandom_range(0, 2))
      0:       return OP_DEL_FRONT;
      1:       return OP_DEL_BACK;
      default: return OP_DEL_AT;
    endcase
  endfunction

  // ---------------- tests ----------------
  task automatic test_empty_store();
    send_item(OP_DEL_FRONT, 32'sd5, 6'd1);
    send_item(OP_DEL_BACK,  32'sd5, 6'd1);
    send_item(OP_DEL_AT,    32'sd5, 6'd1);
    send_item(OP_DEL_AT,    32'sd5, 6'd0);
    send_item(OP_READ_ALL,  32'sd0, 6'd0);
    send_item(OP_INS_AT,    32'sd7, 6'd0);
    send_item(OP_INS_AT,    32'sd7, 6'd2);
    send_item(OP_UNUSED,    32'sd0, 6'd63);
  endtask

  task automatic test_single_element();
    send_item(OP_INS_AT,    32'sh8000_0000, 6'd1);
    send_item(OP_DEL_AT,    32'sd0, 6'd2);
    send_item(OP_DEL_AT,    32'sd0, 6'd0);
    send_item(OP_READ_ALL,  32'sd0, 6'd0);
    send_item(OP_DEL_AT,    32'sd0, 6'd1);
    send_item(OP_INS_FRONT, 32'sh7FFF_FFFF, 6'd0);
    send_item(OP_DEL_BACK,  32'sd0, 6'd0);
    send_item(OP_INS_BACK,  -32'sd1, 6'd63);
    send_item(OP_DEL_FRONT, 32'sd0, 6'd0);
  endtask

  task automatic test_positional_moves();
    send_item(OP_INS_BACK,  32'sd10, 6'd0);
    send_item(OP_INS_BACK,  32'sd30, 6'd0);
    send_item(OP_INS_AT,    32'sd20, 6'd2);
    send_item(OP_INS_AT,    32'sd40, 6'd4);
    send_item(OP_INS_AT,    32'sd50, 6'd6);
    send_item(OP_DEL_AT,    32'sd0, 6'd2);
    send_item(OP_DEL_AT,    32'sd0, 6'd63);
    send_item(OP_READ_ALL,  32'sd0, 6'd0);
  endtask

  // fill to capacity with random content, then probe the full boundary
  task automatic test_full_boundary();
    op_t op;
    while (list_len < CAPACITY) begin
      op = op_t'($urandom_range(0, 2) == 2 ? OP_INS_AT : $urandom_range(0, 1));
      send_item(op, pick_value(), 6'($urandom_range(1, list_len + 1)));
    end
    send_item(OP_INS_FRONT, pick_value(), 6'd0);
    send_item(OP_INS_BACK,  pick_value(), 6'd0);
    send_item(OP_INS_AT,    pick_value(), 6'd33);
    send_item(OP_INS_AT,    pick_value(), 6'd34);
    send_item(OP_INS_AT,    pick_value(), 6'd1);
    send_item(OP_READ_ALL,  32'sd0, 6'd0);
    send_item(OP_DEL_AT,    32'sd0, 6'd33);
    send_item(OP_DEL_AT,    32'sd0, 6'd1);
    send_item(OP_DEL_AT,    32'sd0, 6'd31);
  endtask

  task automatic test_random_mix(int unsigned n_items);
    int unsigned target;
    int unsigned episode;
    int unsigned fill_pct;
    op_t         op;
    target = items_sent + n_items;
    while (items_sent < target) begin
      case ($urandom_range(0, 2))
        0:       fill_pct = 85;
        1:       fill_pct = 20;
        default: fill_pct = 50;
      endcase
      episode = $urandom_range(10, 40);
      repeat (episode) begin
        op = pick_op(fill_pct);
        send_item(op, pick_value(), pick_position(op));
      end
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    start       = 1'b0;
    in_op       = OP_INS_FRONT;
    in_value    = '0;
    in_position = '0;
    list_len    = 0;
    mismatches  = 0;
    items_sent  = 0;
    no_gap_left = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_store();
    test_single_element();
    test_positional_moves();
    test_full_boundary();
    test_random_mix(180);
    test_full_boundary();
    test_random_mix(180);

    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
